@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files of the packet framer.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock with an active-low reset.
`define PFCM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Same, on the default clock and reset names of the block.
`define PFCM_ASSERT_DEF(lbl, prop) `PFCM_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

@@ design/pfcm_pkg.sv @@
// Package of the packet framer: constants, queue entry and AES control types,
// and the AES-128 round functions. No dependencies.
`timescale 1ns / 1ps
package pfcm_pkg;

  localparam int MAX_MESSAGE_BYTES = 1024;
  localparam int HEADER_BYTES      = 8;
  localparam int TAG_BYTES         = 16;
  localparam logic [9:0] PAYLOAD_LIMIT = 10'(MAX_MESSAGE_BYTES - HEADER_BYTES);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    REG_KEY_UPPER = 3'd0,
    REG_KEY_LOWER = 3'd1,
    REG_IV_UPPER  = 3'd2,
    REG_IV_LOWER  = 3'd3,
    REG_NODE_ID   = 3'd4
  } reg_idx_e;

  typedef enum logic {
    ENT_START = 1'b0,
    ENT_BYTE  = 1'b1
  } ent_kind_e;

  typedef struct packed {
    ent_kind_e   kind;
    logic        fin;
    logic [9:0]  len;
    logic [31:0] serial;
    logic [7:0]  data;
  } entry_t;

  typedef struct packed {
    logic         start;
    logic [127:0] block;
  } aes_req_t;

  typedef struct packed {
    logic         busy;
    logic [127:0] result;
  } aes_rsp_t;

  localparam logic [7:0] SBOX_TBL [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_TBL[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, n0, n1, n2, n3;
    t  = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        t[row + 4*c] = sbox(s[127 - 8*(row + 4*((c + row) % 4)) -: 8]);
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0  = t[4*c];
        a1  = t[4*c + 1];
        a2  = t[4*c + 2];
        a3  = t[4*c + 3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]     = a0 ^ all ^ xt(a0 ^ a1);
        t[4*c + 1] = a1 ^ all ^ xt(a1 ^ a2);
        t[4*c + 2] = a2 ^ all ^ xt(a2 ^ a3);
        t[4*c + 3] = a3 ^ all ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8*i -: 8] = t[i] ^ rk[127 - 8*i -: 8];
    end
    return r;
  endfunction

endpackage

@@ design/pfcm_front.sv @@
// Front part of the packet framer: accepts items, tracks the open packet and
// queues start and payload entries for the back part. Uses pfcm_pkg.
`timescale 1ns / 1ps
module pfcm_front import pfcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // serial[31:0], length[41:32], data_byte[49:42]
  input  logic        s_axis_tuser,  // command
  input  logic        pop_i,
  output entry_t      head_o,
  output logic        head_valid_o
);

  entry_t         q_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   count_q, count_d;
  logic           active_q, active_d;
  logic [9:0]     rem_q, rem_d;
  logic           accept, push;
  logic [9:0]     len_in, len_sat;
  entry_t         ent;

  assign s_axis_tready = (count_q != (QAW+1)'(QDEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign len_in        = s_axis_tdata[41:32];
  assign len_sat       = (len_in > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : len_in;
  assign head_o        = q_q[rd_ptr_q];
  assign head_valid_o  = (count_q != '0);

  always_comb begin
    push       = 1'b0;
    active_d   = active_q;
    rem_d      = rem_q;
    ent.kind   = ENT_START;
    ent.fin    = 1'b0;
    ent.len    = len_sat;
    ent.serial = s_axis_tdata[31:0];
    ent.data   = s_axis_tdata[49:42];
    if (accept) begin
      if (s_axis_tuser == ENT_START) begin
        push     = 1'b1;
        ent.fin  = (len_sat == '0);
        active_d = (len_sat != '0);
        rem_d    = len_sat;
      end else if (active_q) begin
        push     = 1'b1;
        ent.kind = ENT_BYTE;
        ent.fin  = (rem_q == 10'd1);
        rem_d    = rem_q - 10'd1;
        active_d = (rem_q != 10'd1);
      end
    end
    count_d = count_q + (QAW+1)'(push) - (QAW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      active_q <= 1'b0;
      rem_q    <= '0;
    end else begin
      count_q  <= count_d;
      active_q <= active_d;
      rem_q    <= rem_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= ent;
    end
  end

endmodule

@@ design/pfcm_aes.sv @@
// Iterative AES-128 encryption unit, one round per cycle with on-the-fly key
// expansion. Uses pfcm_pkg.
`timescale 1ns / 1ps
module pfcm_aes import pfcm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [127:0] key_i,
  input  aes_req_t     req_i,
  output aes_rsp_t     rsp_o
);

  logic [127:0] state_q, rk_q, rk_nxt;
  logic [3:0]   rnd_q;
  logic         busy_q;

  assign rk_nxt      = key_next(rk_q, rcon(rnd_q));
  assign rsp_o.busy   = busy_q;
  assign rsp_o.result = state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      rnd_q  <= 4'd1;
    end else if (busy_q) begin
      rnd_q <= rnd_q + 4'd1;
      if (rnd_q == 4'd10) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      state_q <= req_i.block ^ key_i;
      rk_q    <= key_i;
    end else if (busy_q) begin
      state_q <= aes_round(state_q, rk_nxt, rnd_q == 4'd10);
      rk_q    <= rk_nxt;
    end
  end

endmodule

@@ design/pfcm_back.sv @@
// Back part of the packet framer: emits header, payload and tag bytes, fills
// the MAC block and drives the AES unit. Uses pfcm_pkg.
`timescale 1ns / 1ps
module pfcm_back import pfcm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  entry_t       head_i,
  input  logic         head_valid_i,
  output logic         pop_o,
  input  logic [127:0] iv_i,
  input  logic [7:0]   node_id_i,
  output aes_req_t     aes_req_o,
  input  aes_rsp_t     aes_rsp_i,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,  // out_byte
  output logic         m_axis_tlast   // end_of_packet
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HDR  = 4'b0010,
    ST_PAD  = 4'b0100,
    ST_TAG  = 4'b1000
  } state_e;

  state_e       state_q, state_d;
  logic [7:0]   buf_q [16];
  logic [3:0]   fill_q, cnt_q;
  logic [63:0]  hdr_q;
  logic [127:0] chain_q, tag_q, chain, blk;
  logic         fin_q, use_aes_q, ovalid_q, olast_q;
  logic [7:0]   obyte_q;
  logic         out_free, absorb_ok;
  logic         emit, elast, absorb, load_start, launch_pad, load_tag;
  logic [7:0]   ebyte, abyte;
  logic         launch_full;

  assign chain     = use_aes_q ? aes_rsp_i.result : chain_q;
  assign out_free  = !ovalid_q || m_axis_tready;
  assign absorb_ok = !((fill_q == 4'd15) && aes_rsp_i.busy);
  assign launch_full = absorb && (fill_q == 4'd15);

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obyte_q;
  assign m_axis_tlast  = olast_q;

  always_comb begin
    state_d    = state_q;
    emit       = 1'b0;
    elast      = 1'b0;
    ebyte      = head_i.data;
    absorb     = 1'b0;
    abyte      = head_i.data;
    pop_o      = 1'b0;
    load_start = 1'b0;
    launch_pad = 1'b0;
    load_tag   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          if (head_i.kind == ENT_BYTE) begin
            if (out_free && absorb_ok) begin
              emit   = 1'b1;
              absorb = 1'b1;
              pop_o  = 1'b1;
              if (head_i.fin) begin
                state_d = ST_PAD;
              end
            end
          end else if (!aes_rsp_i.busy) begin
            pop_o      = 1'b1;
            load_start = 1'b1;
            state_d    = ST_HDR;
          end
        end
      end
      ST_HDR: begin
        ebyte = hdr_q[63:56];
        abyte = hdr_q[63:56];
        if (out_free && absorb_ok) begin
          emit   = 1'b1;
          absorb = 1'b1;
          if (cnt_q == 4'(HEADER_BYTES - 1)) begin
            state_d = fin_q ? ST_PAD : ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        if (!aes_rsp_i.busy) begin
          if (fill_q != '0) begin
            launch_pad = 1'b1;
          end else begin
            load_tag = 1'b1;
            state_d  = ST_TAG;
          end
        end
      end
      ST_TAG: begin
        ebyte = tag_q[127:120];
        elast = (cnt_q == 4'(TAG_BYTES - 1));
        if (out_free) begin
          emit = 1'b1;
          if (elast) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (launch_full) begin
        blk[127 - 8*i -: 8] = (i == 15) ? abyte : buf_q[i];
      end else begin
        blk[127 - 8*i -: 8] = (4'(i) < fill_q) ? buf_q[i] : 8'h00;
      end
    end
    aes_req_o.start = launch_full || launch_pad;
    aes_req_o.block = chain ^ blk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      cnt_q     <= '0;
      fin_q     <= 1'b0;
      use_aes_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      if (load_start) begin
        fill_q    <= '0;
        cnt_q     <= '0;
        fin_q     <= head_i.fin;
        use_aes_q <= 1'b0;
      end else begin
        if (absorb) begin
          fill_q <= fill_q + 4'd1;
        end
        if (launch_pad) begin
          fill_q <= '0;
        end
        if (aes_req_o.start) begin
          use_aes_q <= 1'b1;
        end
        if (emit && (state_q != ST_IDLE)) begin
          cnt_q <= cnt_q + 4'd1;
        end
        if (load_tag) begin
          cnt_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      obyte_q <= ebyte;
      olast_q <= elast;
    end
    if (absorb) begin
      buf_q[fill_q] <= abyte;
    end
    if (load_start) begin
      chain_q <= iv_i;
      hdr_q   <= {8'h00, node_id_i, 6'b0, head_i.len, head_i.serial};
    end else if (state_q == ST_HDR && emit) begin
      hdr_q <= {hdr_q[55:0], 8'h00};
    end
    if (load_tag) begin
      tag_q <= chain;
    end else if (state_q == ST_TAG && emit) begin
      tag_q <= {tag_q[119:0], 8'h00};
    end
  end

endmodule

@@ design/packet_framer_cbc_mac.sv @@
// Top level of the packet framer with AES-128 CBC-MAC: configuration registers
// and the front, back and AES units. Uses pfcm_pkg, pfcm_front, pfcm_back, pfcm_aes.
//
// Channel   Direction  Signals                      Content
// s_axis    in         tvalid tready tdata tuser    command, serial, length, byte
// m_axis    out        tvalid tready tdata tlast    framed byte, end of packet
// apb       in/out     psel penable pwrite paddr..  key, IV, node id
//
// The output carries at most one byte per cycle; a start item yields 8 header
// bytes, a payload item of an open packet one byte, and the final item 16 tag bytes.
// The iterative AES unit processes one block at a time and sets the tag latency.
// A start item waits until the AES unit is free, then loads the header.
// Reset clears all control state; no clearing pass is needed.
`timescale 1ns / 1ps
module packet_framer_cbc_mac import pfcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // serial[31:0], length[41:32], data_byte[49:42]
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tlast,  // end_of_packet
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] key_upper_q, key_lower_q, iv_upper_q, iv_lower_q;
  logic [7:0]  node_id_q;
  logic        wr_en;
  reg_idx_e    idx;
  entry_t      head;
  logic        head_valid, pop;
  aes_req_t    aes_req;
  aes_rsp_t    aes_rsp;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[5:3]);

  always_comb begin
    unique case (idx)
      REG_KEY_UPPER: prdata = key_upper_q;
      REG_KEY_LOWER: prdata = key_lower_q;
      REG_IV_UPPER:  prdata = iv_upper_q;
      REG_IV_LOWER:  prdata = iv_lower_q;
      REG_NODE_ID:   prdata = {56'b0, node_id_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
      iv_upper_q  <= '0;
      iv_lower_q  <= '0;
      node_id_q   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_KEY_UPPER: key_upper_q <= pwdata;
        REG_KEY_LOWER: key_lower_q <= pwdata;
        REG_IV_UPPER:  iv_upper_q  <= pwdata;
        REG_IV_LOWER:  iv_lower_q  <= pwdata;
        REG_NODE_ID:   node_id_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  pfcm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_i         (pop),
    .head_o        (head),
    .head_valid_o  (head_valid)
  );

  pfcm_aes u_aes (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  ({key_upper_q, key_lower_q}),
    .req_i  (aes_req),
    .rsp_o  (aes_rsp)
  );

  pfcm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (head_valid),
    .pop_o         (pop),
    .iv_i          ({iv_upper_q, iv_lower_q}),
    .node_id_i     (node_id_q),
    .aes_req_o     (aes_req),
    .aes_rsp_i     (aes_rsp),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ design/pfcm_checker.sv @@
// Port-level checker for the packet framer, bound to the top level.
// Uses pfcm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfcm_checker import pfcm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [5:0]  paddr,
  input logic [63:0] pwdata,
  input logic [63:0] prdata
);

  `PFCM_ASSERT_DEF(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `PFCM_ASSERT_DEF(a_key_readback, psel && penable && pwrite && paddr[5:3] == REG_KEY_UPPER |=> paddr[5:3] != REG_KEY_UPPER || prdata == $past(pwdata))
  `PFCM_ASSERT_DEF(a_node_readback, psel && penable && pwrite && paddr[5:3] == REG_NODE_ID |=> paddr[5:3] != REG_NODE_ID || prdata == {56'b0, $past(pwdata[7:0])})

endmodule

bind packet_framer_cbc_mac pfcm_checker u_pfcm_checker (.*);

@@ dv/tb_top.sv @@
// Testbench for packet_framer_cbc_mac: drives start and payload items, predicts the
// framed header, payload and AES-128 CBC-MAC tag bytes, and compares them. Uses pfcm_pkg.
`timescale 1ns / 1ps

class frame_scoreboard;
  logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
  logic [7:0]  node;
  logic [127:0] chain;
  logic [7:0]  blk [16];
  int unsigned fill;
  int unsigned remaining;
  bit          open_pkt;
  logic [8:0]  pending [$];
  int unsigned errors;

  function void clear();
    key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0; node = '0;
    chain = '0; fill = 0; remaining = 0; open_pkt = 0;
    pending.delete(); errors = 0;
  endfunction

  function void write_reg(pfcm_pkg::reg_idx_e idx, logic [63:0] v);
    case (idx)
      pfcm_pkg::REG_KEY_UPPER: key_hi = v;
      pfcm_pkg::REG_KEY_LOWER: key_lo = v;
      pfcm_pkg::REG_IV_UPPER:  iv_hi = v;
      pfcm_pkg::REG_IV_LOWER:  iv_lo = v;
      pfcm_pkg::REG_NODE_ID:   node = v[7:0];
      default: ;
    endcase
  endfunction

  function logic [7:0] mul2(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function logic [127:0] encrypt(logic [127:0] st);
    logic [7:0] w [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a, b, c, d, r, rc, x0, x1, x2, x3, al;
    logic [127:0] res;
    for (int i = 0; i < 8; i++) begin
      w[i] = key_hi[63 - 8*i -: 8];
      w[8 + i] = key_lo[63 - 8*i -: 8];
    end
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      a = w[i-4]; b = w[i-3]; c = w[i-2]; d = w[i-1];
      if (i % 16 == 0) begin
        r = a;
        a = pfcm_pkg::SBOX_TBL[b] ^ rc;
        b = pfcm_pkg::SBOX_TBL[c]; c = pfcm_pkg::SBOX_TBL[d]; d = pfcm_pkg::SBOX_TBL[r];
        rc = mul2(rc);
      end
      w[i] = w[i-16] ^ a; w[i+1] = w[i-15] ^ b;
      w[i+2] = w[i-14] ^ c; w[i+3] = w[i-13] ^ d;
    end
    for (int i = 0; i < 16; i++) s[i] = st[127 - 8*i -: 8] ^ w[i];
    for (int rd = 1; rd <= 10; rd++) begin
      for (int cc = 0; cc < 4; cc++)
        for (int rr = 0; rr < 4; rr++)
          t[rr + 4*cc] = pfcm_pkg::SBOX_TBL[s[rr + 4*((cc + rr) % 4)]];
      if (rd != 10) begin
        for (int cc = 0; cc < 4; cc++) begin
          x0 = t[4*cc]; x1 = t[4*cc+1]; x2 = t[4*cc+2]; x3 = t[4*cc+3];
          al = x0 ^ x1 ^ x2 ^ x3;
          t[4*cc] = x0 ^ al ^ mul2(x0 ^ x1);
          t[4*cc+1] = x1 ^ al ^ mul2(x1 ^ x2);
          t[4*cc+2] = x2 ^ al ^ mul2(x2 ^ x3);
          t[4*cc+3] = x3 ^ al ^ mul2(x3 ^ x0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[16*rd + i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
    return res;
  endfunction

  function void absorb(logic [7:0] v);
    logic [127:0] m;
    blk[fill] = v;
    fill++;
    if (fill == 16) begin
      for (int i = 0; i < 16; i++) m[127 - 8*i -: 8] = blk[i];
      chain = encrypt(chain ^ m);
      fill = 0;
    end
  endfunction

  function void emit_byte(logic [7:0] v);
    pending.push_back({1'b0, v});
    absorb(v);
  endfunction

  function void close_packet();
    if (fill != 0) begin
      while (fill != 0) absorb(8'h00);
    end
    for (int i = 0; i < 16; i++) pending.push_back({i == 15, chain[127 - 8*i -: 8]});
    open_pkt = 0;
    remaining = 0;
  endfunction

  function void note_item(bit is_byte, logic [31:0] serial, logic [9:0] len,
                          logic [7:0] data);
    logic [9:0] l;
    if (!is_byte) begin
      l = (len > pfcm_pkg::PAYLOAD_LIMIT) ? pfcm_pkg::PAYLOAD_LIMIT : len;
      chain = {iv_hi, iv_lo};
      fill = 0;
      remaining = l;
      open_pkt = 1;
      emit_byte(8'h00); emit_byte(node); emit_byte({6'b0, l[9:8]}); emit_byte(l[7:0]);
      emit_byte(serial[31:24]); emit_byte(serial[23:16]);
      emit_byte(serial[15:8]); emit_byte(serial[7:0]);
      if (remaining == 0) close_packet();
    end else if (open_pkt) begin
      emit_byte(data);
      remaining--;
      if (remaining == 0) close_packet();
    end
  endfunction

  function bit check_byte(logic [7:0] v, logic last, output string msg);
    logic [8:0] e;
    if (pending.size() == 0) begin
      msg = $sformatf("unexpected byte %02h last %0b", v, last);
      return 0;
    end
    e = pending.pop_front();
    if (e[7:0] !== v || e[8] !== last) begin
      msg = $sformatf("got byte %02h last %0b, want %02h last %0b", v, last, e[7:0], e[8]);
      return 0;
    end
    return 1;
  endfunction
endclass

module tb_top;
  import pfcm_pkg::*;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [7:0]  m_axis_tdata;
  logic        psel, penable, pwrite, pready;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;

  frame_scoreboard sb;
  int unsigned cycles;
  int unsigned fails;
  bit          calm;
  bit          done;

  packet_framer_cbc_mac DUT (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    fails++;
  endtask

  always @(posedge clk_i) begin
    string msg;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      if (!sb.check_byte(m_axis_tdata, m_axis_tlast, msg)) report(msg);
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 6'(8 * idx); pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic send(bit is_byte, logic [31:0] serial, logic [9:0] len, logic [7:0] data);
    while (!calm && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= is_byte;
    s_axis_tdata <= {6'b0, data, len, serial};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(is_byte, serial, len, data);
  endtask

  task automatic wait_empty();
    s_axis_tvalid <= 0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  task automatic drain();
    wait_empty();
    repeat (40) @(posedge clk_i);
  endtask

  task automatic packet(logic [9:0] len, bit full);
    int unsigned n;
    n = (len > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : len;
    send(0, $urandom, len, 8'($urandom));
    if (!full) n = $urandom_range(n);
    for (int i = 0; i < n; i++) send(1, $urandom, 10'($urandom), 8'($urandom));
  endtask

  task automatic random_config();
    write_reg(REG_KEY_UPPER, {$urandom, $urandom});
    write_reg(REG_KEY_LOWER, {$urandom, $urandom});
    write_reg(REG_IV_UPPER, {$urandom, $urandom});
    write_reg(REG_IV_LOWER, {$urandom, $urandom});
    write_reg(REG_NODE_ID, 64'($urandom_range(255)));
  endtask

  initial begin
    sb = new();
    sb.clear();
    cycles = 0; fails = 0; calm = 0; done = 0;
    rst_ni = 0;
    s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = '0; m_axis_tready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: zero key and IV, zero-length packet, stray byte while idle.
    send(1, 32'hFFFF_FFFF, 10'h3FF, 8'hFF);
    send(0, 32'h0000_0000, 10'd0, 8'h00);
    drain();
    write_reg(REG_KEY_UPPER, '1);
    write_reg(REG_KEY_LOWER, '1);
    write_reg(REG_IV_UPPER, '1);
    write_reg(REG_IV_LOWER, '1);
    write_reg(REG_NODE_ID, 64'hFF);
    // Header plus 8 bytes is an exact block multiple; then a restart mid-packet.
    send(0, 32'hFFFF_FFFF, 10'd8, 8'h00);
    for (int i = 0; i < 8; i++) send(1, 32'hFFFF_FFFF, 10'h3FF, i[0] ? 8'hFF : 8'h00);
    send(0, 32'h1234_5678, 10'd5, 8'h00);
    send(1, 32'h0, 10'd0, 8'hA5);
    send(0, 32'h8000_0001, 10'd3, 8'h00);
    for (int i = 0; i < 3; i++) send(1, 32'h0, 10'd0, 8'h5A);
    drain();
    // Oversized length saturates; the packet is cut off by a new start.
    send(0, 32'hDEAD_BEEF, 10'h3FF, 8'h00);
    send(1, 32'h0, 10'd0, 8'h01);
    send(0, 32'h0, 10'd1, 8'h00);
    send(1, 32'h0, 10'd0, 8'h80);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      random_config();
      if (phase == 3) write_reg(REG_NODE_ID, 64'h00);
      calm = (phase == 2);
      for (int p = 0; p < 5; p++) begin
        case ($urandom_range(9))
          0: send(1, $urandom, 10'($urandom), 8'($urandom));
          1: packet(10'($urandom_range(16)), 0);
          default: packet(10'($urandom_range(8)), 1);
        endcase
        if (p == 2) wait_empty();
      end
      drain();
    end
    done = 1;
  end

  initial begin
    wait (done || cycles >= 200000);
    if (!done) begin
      $display("FAIL packet_framer_cbc_mac");
    end else if (fails == 0 && sb.pending.size() == 0) begin
      $display("PASS packet_framer_cbc_mac");
    end else begin
      $display("FAIL packet_framer_cbc_mac");
    end
    $finish;
  end
endmodule
